// ===== rtl/core/bdq_pkg.sv =====
// Package for the bounded deque with search.
// Holds the request, status and cell command codes, and the shared types.
// Has no dependencies.
`default_nettype none

package bdq_pkg;

  localparam int BDQ_DEPTH = 16;
  localparam int WORD_W    = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam logic [2:0] ACT_INS_FRONT = 3'd0;
  localparam logic [2:0] ACT_INS_REAR  = 3'd1;
  localparam logic [2:0] ACT_REM_FRONT = 3'd2;
  localparam logic [2:0] ACT_REM_REAR  = 3'd3;
  localparam logic [2:0] ACT_LIST      = 3'd4;
  localparam logic [2:0] ACT_SEARCH    = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam logic [2:0] CMD_HOLD   = 3'd0;
  localparam logic [2:0] CMD_SHR    = 3'd1;
  localparam logic [2:0] CMD_SHL    = 3'd2;
  localparam logic [2:0] CMD_ROT    = 3'd3;
  localparam logic [2:0] CMD_APPEND = 3'd4;

  typedef struct packed {
    logic [2:0] cmd;
    word_t      key;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/bdq_cell.sv =====
// One storage cell of the deque chain: a value and its valid bit.
// Shifts, rotates or appends on the broadcast command; compares with the key.
// Depends on bdq_pkg.
`default_nettype none

module bdq_cell
  import bdq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_ctl_t ctl,
  input  wire word_t     left_val,
  input  wire logic      left_vld,
  input  wire word_t     right_val,
  input  wire logic      right_vld,
  input  wire word_t     head_val,
  output word_t          val,
  output logic           vld,
  output logic           hit
);

  word_t val_r, val_nxt;
  logic  vld_r, vld_nxt;

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    case (ctl.cmd)
      CMD_SHR: begin
        val_nxt = left_val;
        vld_nxt = left_vld;
      end
      CMD_SHL: begin
        val_nxt = right_val;
        vld_nxt = right_vld;
      end
      CMD_ROT: begin
        if (right_vld) begin
          val_nxt = right_val;
        end else if (vld_r) begin
          val_nxt = head_val;
        end
      end
      CMD_APPEND: begin
        if (!vld_r && left_vld) begin
          val_nxt = ctl.key;
          vld_nxt = 1'b1;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign vld = vld_r;
  assign hit = vld_r && (val_r == ctl.key);

endmodule

`default_nettype wire

// ===== rtl/core/bounded_deque_with_search.sv =====
// Bounded double-ended queue of signed 32-bit words with search.
// Top level: request sequencer over a chain of bdq_cell; depends on bdq_pkg.
//
// Usage: a request (in_action, in_item) transfers when in_valid is high and
// in_stall is low. Results leave on out_status, out_value and out_last, one
// per transfer on the result channel; out_last marks the final result of a
// request. Front is cell 0 of the chain.
// Inserts and front removes answer in the cycle after the transfer, and a new
// request may follow at once if out_stall is low. Search registers the
// per-cell compare, then the result. Remove rear rotates the chain left
// until the rear word reaches cell 0, then removes it. List gives one result
// per cycle from cell 0 while the chain rotates unless stalled, occupancy
// results in all, up to DEPTH. Unused action codes transfer and give nothing.
// Reset: the store is empty after rst_n; cell data is left as is.
// Stall: while out_stall holds a result, the sequencer waits and in_stall
// stays high; a request is only taken when the output register is free or
// being emptied in the same cycle.
`default_nettype none

module bounded_deque_with_search
  import bdq_pkg::*;
#(
  parameter int DEPTH = BDQ_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_action,
  input  wire word_t       in_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output word_t            out_value,
  output logic             out_last
);

  localparam int OW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LIST = 2'd1;
  localparam logic [1:0] S_REAR = 2'd2;
  localparam logic [1:0] S_SRCH = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [OW-1:0] occ_r, occ_nxt;
  logic [OW-1:0] cnt_r, cnt_nxt;
  logic          hit_r, hit_nxt;
  logic          ovld_r, ovld_nxt;
  logic [1:0]    ostat_r, ostat_nxt;
  word_t         oval_r, oval_nxt;
  logic          olast_r, olast_nxt;

  cell_ctl_t         ctl;
  word_t             cell_val [DEPTH];
  logic [DEPTH-1:0]  cell_vld;
  logic [DEPTH-1:0]  cell_hit;
  word_t             head_val;
  logic              out_free;
  logic              in_take;
  logic              full;
  logic              empty;
  logic [OW-1:0]     occ_last;

  assign head_val = cell_val[0];
  assign out_free = !ovld_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_take  = in_valid && !in_stall;
  assign full     = (occ_r == OW'(DEPTH));
  assign empty    = (occ_r == '0);
  assign occ_last = occ_r - OW'(1);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t lval, rval;
    logic  lvld, rvld;
    if (i == 0) begin : g_first
      assign lval = in_item;
      assign lvld = 1'b1;
    end else begin : g_mid_l
      assign lval = cell_val[i-1];
      assign lvld = cell_vld[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rval = '0;
      assign rvld = 1'b0;
    end else begin : g_mid_r
      assign rval = cell_val[i+1];
      assign rvld = cell_vld[i+1];
    end
    bdq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .left_val  (lval),
      .left_vld  (lvld),
      .right_val (rval),
      .right_vld (rvld),
      .head_val  (head_val),
      .val       (cell_val[i]),
      .vld       (cell_vld[i]),
      .hit       (cell_hit[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    occ_nxt   = occ_r;
    cnt_nxt   = cnt_r;
    hit_nxt   = hit_r;
    ovld_nxt  = ovld_r && out_stall;
    ostat_nxt = ostat_r;
    oval_nxt  = oval_r;
    olast_nxt = olast_r;
    ctl.cmd   = CMD_HOLD;
    ctl.key   = in_item;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          ostat_nxt = ST_OK;
          oval_nxt  = '0;
          olast_nxt = 1'b1;
          case (in_action)
            ACT_INS_FRONT, ACT_INS_REAR: begin
              ovld_nxt = 1'b1;
              if (full) begin
                ostat_nxt = ST_FULL;
              end else begin
                ctl.cmd = (in_action == ACT_INS_FRONT) ? CMD_SHR : CMD_APPEND;
                occ_nxt = occ_r + OW'(1);
              end
            end
            ACT_REM_FRONT: begin
              ovld_nxt = 1'b1;
              if (empty) begin
                ostat_nxt = ST_EMPTY;
              end else begin
                ctl.cmd  = CMD_SHL;
                occ_nxt  = occ_last;
                oval_nxt = head_val;
              end
            end
            ACT_REM_REAR: begin
              if (empty) begin
                ovld_nxt  = 1'b1;
                ostat_nxt = ST_EMPTY;
              end else if (occ_r == OW'(1)) begin
                ovld_nxt = 1'b1;
                ctl.cmd  = CMD_SHL;
                occ_nxt  = occ_last;
                oval_nxt = head_val;
              end else begin
                ctl.cmd   = CMD_ROT;
                cnt_nxt   = OW'(1);
                state_nxt = S_REAR;
              end
            end
            ACT_LIST: begin
              if (empty) begin
                ovld_nxt  = 1'b1;
                ostat_nxt = ST_EMPTY;
              end else begin
                cnt_nxt   = '0;
                state_nxt = S_LIST;
              end
            end
            ACT_SEARCH: begin
              if (empty) begin
                ovld_nxt  = 1'b1;
                ostat_nxt = ST_EMPTY;
              end else begin
                hit_nxt   = |cell_hit;
                state_nxt = S_SRCH;
              end
            end
            default: begin
              ostat_nxt = ostat_r;
              oval_nxt  = oval_r;
              olast_nxt = olast_r;
            end
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          ostat_nxt = ST_OK;
          oval_nxt  = head_val;
          olast_nxt = (cnt_r == occ_last);
          ctl.cmd   = CMD_ROT;
          if (cnt_r == occ_last) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + OW'(1);
          end
        end
      end
      S_REAR: begin
        if (cnt_r == occ_last) begin
          if (out_free) begin
            ovld_nxt  = 1'b1;
            ostat_nxt = ST_OK;
            oval_nxt  = head_val;
            olast_nxt = 1'b1;
            ctl.cmd   = CMD_SHL;
            occ_nxt   = occ_last;
            state_nxt = S_IDLE;
          end
        end else begin
          ctl.cmd = CMD_ROT;
          cnt_nxt = cnt_r + OW'(1);
        end
      end
      S_SRCH: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          ostat_nxt = hit_r ? ST_OK : ST_MISSING;
          oval_nxt  = '0;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r   <= hit_nxt;
    ostat_r <= ostat_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid  = ovld_r;
  assign out_status = ostat_r;
  assign out_value  = oval_r;
  assign out_last   = olast_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(DEPTH))
    else $error("occupancy above capacity");

  a_vld_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_vld) == int'(occ_r))
    else $error("cell valid bits disagree with occupancy");

  a_vld_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_vld + DEPTH'(1)) & cell_vld) == '0)
    else $error("valid cells not packed toward the front");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire
